FILE: hw/rtl/phsp_pkg.sv
// phsp_pkg: types, codes and constants for the protobuf header session parser
// no dependencies; imported by every module of the parser
`default_nettype none

package phsp_pkg;

    // parser phase; the one unused 3-bit code is treated as stopped
    typedef enum logic [2:0] {
        PH_TAG   = 3'd0,
        PH_FIX64 = 3'd1,
        PH_SESS  = 3'd2,
        PH_SKIPV = 3'd3,
        PH_LEN   = 3'd4,
        PH_SKIPN = 3'd5,
        PH_STOP  = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        END_BOUNDARY  = 2'd0,
        END_CUT       = 2'd1,
        END_MALFORMED = 2'd2
    } t_end_status;

    // wire types
    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_FIX64  = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_FIX32  = 3'd5;

    // field numbers, compared over the whole shifted tag
    localparam int unsigned FIELD_NUM_W   = 61;
    localparam logic [FIELD_NUM_W-1:0] FIELD_ACCOUNT = 61'd1;
    localparam logic [FIELD_NUM_W-1:0] FIELD_SESSION = 61'd2;

    localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;
    localparam logic [6:0] VARINT_DIGIT_W   = 7'd7;
    localparam logic [3:0] FIX64_LAST_BYTE  = 4'd7;
    localparam logic [63:0] SKIP_FIX64_BYTES = 64'd8;
    localparam logic [63:0] SKIP_FIX32_BYTES = 64'd4;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [63:0] account_id;
        logic [31:0] session_id;
        t_end_status end_status;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/phsp_if.sv
// phsp_in_if / phsp_out_if: valid/ready channels for header bytes and results
// no dependencies; used by the parser top level and its stage modules
`default_nettype none

interface phsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_byte;
    logic       is_last;

    modport source (output valid, output header_byte, output is_last, input ready);
    modport sink   (input valid, input header_byte, input is_last, output ready);
endinterface

interface phsp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] account_id;
    logic [31:0] session_id;
    logic [1:0]  end_status;

    modport source (output valid, output account_id, output session_id, output end_status,
                    input ready);
    modport sink   (input valid, input account_id, input session_id, input end_status,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/phsp_in_reg.sv
// phsp_in_reg: input register stage for header bytes
// depends on phsp_pkg and phsp_in_if
`default_nettype none

module phsp_in_reg
    import phsp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    phsp_in_if.sink  i_hdr,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    assign i_hdr.ready = !r_valid || i_take;
    assign o_valid     = r_valid;
    assign o_item      = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_hdr.ready) begin
            r_valid <= i_hdr.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_hdr.valid && i_hdr.ready) begin
            r_item.header_byte <= i_hdr.header_byte;
            r_item.is_last     <= i_hdr.is_last;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/phsp_core.sv
// phsp_core: wire format decode state, held ids and end status for one byte
// depends on phsp_pkg
`default_nettype none

module phsp_core
    import phsp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_in_item i_item,
    output t_result  o_result
);

    t_phase      r_phase;
    logic [63:0] r_accum;
    logic [3:0]  r_count;
    logic [63:0] r_skip;
    logic [63:0] r_acct;
    logic [31:0] r_sess;

    t_phase      s_phase;
    logic [63:0] s_accum;
    logic [3:0]  s_count;
    logic [63:0] s_skip;
    logic [63:0] s_acct;
    logic [31:0] s_sess;

    t_phase      n_phase;
    logic [63:0] n_accum;
    logic [3:0]  n_count;
    logic [63:0] n_skip;
    logic [63:0] n_acct;
    logic [31:0] n_sess;

    logic [6:0]             v_shamt;
    logic [63:0]            v_digit;
    logic [63:0]            v_accum;
    logic                   v_cont;
    logic [3:0]             v_count;
    logic                   v_long;
    logic [FIELD_NUM_W-1:0] t_fn;
    logic [2:0]             t_wt;
    logic [63:0]            f_accum;
    logic                   f_done;
    logic [63:0]            k_dec;
    logic                   k_zero;
    t_end_status            s_status;

    // varint digit placement
    assign v_shamt = 7'(r_count) * VARINT_DIGIT_W;
    assign v_digit = (v_shamt <= 7'd63) ?
                     (64'(i_item.header_byte[6:0]) << v_shamt[5:0]) : 64'd0;
    assign v_accum = r_accum | v_digit;
    assign v_cont  = i_item.header_byte[7];
    assign v_count = r_count + 4'd1;
    assign v_long  = v_cont && (v_count >= VARINT_MAX_BYTES);

    // tag fields
    assign t_fn = v_accum[63:3];
    assign t_wt = v_accum[2:0];

    // fixed64 little-endian byte placement
    assign f_accum = r_accum | (64'(i_item.header_byte) << {r_count[2:0], 3'b000});
    assign f_done  = (r_count == FIX64_LAST_BYTE);

    // skip countdown
    assign k_dec  = r_skip - 64'(r_skip != 64'd0);
    assign k_zero = (k_dec == 64'd0);

    // next phase
    always_comb begin
        s_phase = r_phase;
        unique case (r_phase)
            PH_TAG: begin
                if (v_long) begin
                    s_phase = PH_STOP;
                end else if (!v_cont) begin
                    priority if (t_fn == FIELD_ACCOUNT && t_wt == WT_FIX64) begin
                        s_phase = PH_FIX64;
                    end else if (t_fn == FIELD_SESSION && t_wt == WT_VARINT) begin
                        s_phase = PH_SESS;
                    end else if (t_wt == WT_VARINT) begin
                        s_phase = PH_SKIPV;
                    end else if (t_wt == WT_FIX64) begin
                        s_phase = PH_SKIPN;
                    end else if (t_wt == WT_LEN) begin
                        s_phase = PH_LEN;
                    end else if (t_wt == WT_FIX32) begin
                        s_phase = PH_SKIPN;
                    end else begin
                        s_phase = PH_STOP;
                    end
                end
            end
            PH_FIX64: begin
                if (f_done) begin
                    s_phase = PH_TAG;
                end
            end
            PH_SESS, PH_SKIPV: begin
                if (v_long) begin
                    s_phase = PH_STOP;
                end else if (!v_cont) begin
                    s_phase = PH_TAG;
                end
            end
            PH_LEN: begin
                if (v_long) begin
                    s_phase = PH_STOP;
                end else if (!v_cont) begin
                    s_phase = (v_accum == 64'd0) ? PH_TAG : PH_SKIPN;
                end
            end
            PH_SKIPN: begin
                if (k_zero) begin
                    s_phase = PH_TAG;
                end
            end
            PH_STOP: begin
                s_phase = PH_STOP;
            end
            default: begin
                s_phase = PH_STOP;
            end
        endcase
    end

    // value registers
    always_comb begin
        s_accum = r_accum;
        s_count = r_count;
        s_skip  = r_skip;
        s_acct  = r_acct;
        s_sess  = r_sess;
        unique case (r_phase)
            PH_TAG, PH_SESS, PH_SKIPV, PH_LEN: begin
                if (v_cont) begin
                    s_accum = v_accum;
                    s_count = v_count;
                end else begin
                    s_accum = 64'd0;
                    s_count = 4'd0;
                    if (r_phase == PH_SESS) begin
                        s_sess = v_accum[31:0];
                    end
                    if (r_phase == PH_LEN) begin
                        s_skip = v_accum;
                    end
                    if (r_phase == PH_TAG && s_phase == PH_SKIPN) begin
                        s_skip = (t_wt == WT_FIX64) ? SKIP_FIX64_BYTES : SKIP_FIX32_BYTES;
                    end
                end
            end
            PH_FIX64: begin
                if (f_done) begin
                    s_acct  = f_accum;
                    s_accum = 64'd0;
                    s_count = 4'd0;
                end else begin
                    s_accum = f_accum;
                    s_count = r_count + 4'd1;
                end
            end
            PH_SKIPN: begin
                s_skip = k_dec;
            end
            default: begin
                s_accum = r_accum;
            end
        endcase
    end

    // end status and clearing after the last byte
    always_comb begin
        priority if (s_phase == PH_TAG && s_count == 4'd0) begin
            s_status = END_BOUNDARY;
        end else if (s_phase == PH_STOP) begin
            s_status = END_MALFORMED;
        end else begin
            s_status = END_CUT;
        end

        o_result.account_id = s_acct;
        o_result.session_id = s_sess;
        o_result.end_status = s_status;

        if (i_item.is_last) begin
            n_phase = PH_TAG;
            n_accum = 64'd0;
            n_count = 4'd0;
            n_skip  = 64'd0;
            n_acct  = 64'd0;
            n_sess  = 32'd0;
        end else begin
            n_phase = s_phase;
            n_accum = s_accum;
            n_count = s_count;
            n_skip  = s_skip;
            n_acct  = s_acct;
            n_sess  = s_sess;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
            r_accum <= 64'd0;
            r_count <= 4'd0;
            r_skip  <= 64'd0;
            r_acct  <= 64'd0;
            r_sess  <= 32'd0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_accum <= n_accum;
            r_count <= n_count;
            r_skip  <= n_skip;
            r_acct  <= n_acct;
            r_sess  <= n_sess;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_STOP) |-> (r_count < VARINT_MAX_BYTES))
        else $error("varint byte count out of range");

    a_fix_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FIX64) |-> (r_count <= FIX64_LAST_BYTE))
        else $error("fixed64 byte count out of range");

    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIPN) |-> (r_skip != 64'd0))
        else $error("skip phase with nothing to skip");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.is_last) |=>
        (r_phase == PH_TAG && r_count == 4'd0 && r_acct == 64'd0 && r_sess == 32'd0))
        else $error("state not cleared after last byte");

endmodule

`default_nettype wire

FILE: hw/rtl/phsp_out_reg.sv
// phsp_out_reg: result register stage holding one header result until taken
// depends on phsp_pkg and phsp_out_if
`default_nettype none

module phsp_out_reg
    import phsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_result,
    output logic       o_free,
    phsp_out_if.source o_res
);

    logic    r_valid;
    t_result r_result;

    assign o_free           = !r_valid || o_res.ready;
    assign o_res.valid      = r_valid;
    assign o_res.account_id = r_result.account_id;
    assign o_res.session_id = r_result.session_id;
    assign o_res.end_status = r_result.end_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/proto_header_session_parser_unit.sv
// proto_header_session_parser_unit: top level of the protobuf header session parser
// depends on phsp_pkg, phsp_if, phsp_in_reg, phsp_core, phsp_out_reg
//
//   channel  dir  payload                                  transfer when
//   i_hdr    in   header_byte[7:0], is_last                valid && ready
//   o_res    out  account_id[63:0], session_id[31:0],      valid && ready
//                 end_status[1:0]
//
// one header byte per cycle while no last byte waits; decode is combinational from the input register
// a result is loaded into the result register as its last byte leaves the input register
// synchronous active-low reset clears phase, counters and held ids
// non-last bytes keep flowing while a result waits; a last byte waits in the
// input register until the result register is free
`default_nettype none

module proto_header_session_parser_unit
    import phsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    phsp_in_if.sink    i_hdr,
    phsp_out_if.source o_res
);

    logic     in_valid;
    t_in_item in_item;
    logic     out_free;
    logic     fire;
    t_result  core_result;

    assign fire = in_valid && (!in_item.is_last || out_free);

    phsp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hdr   (i_hdr),
        .i_take  (fire),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    phsp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (in_item),
        .o_result (core_result)
    );

    phsp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && in_item.is_last),
        .i_result (core_result),
        .o_free   (out_free),
        .o_res    (o_res)
    );

endmodule

`default_nettype wire
